### hdl/gray_histogram_shrink_top_defines.svh
// assertion macros used by the gray histogram shrink back end
`ifndef GRAY_HISTOGRAM_SHRINK_TOP_DEFINES_SVH
`define GRAY_HISTOGRAM_SHRINK_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define GHS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define GHS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/ghs_pkg.sv
// shared types and constants for the gray histogram shrink block
`timescale 1ns / 1ps
package ghs_pkg;

	localparam int PIXEL_BITS = 8;
	localparam int PROD_BITS = 2 * PIXEL_BITS;
	localparam int STEP_BITS = $clog2(PROD_BITS);
	localparam logic [PIXEL_BITS-1:0] PIXEL_TOP = {PIXEL_BITS{1'b1}};

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_BITS = QUEUE_PTR_BITS + 1;

	localparam int CFG_ADDR_BITS = 1;
	localparam logic [CFG_ADDR_BITS-1:0] REG_TARGET_LOW = 1'd0;
	localparam logic [CFG_ADDR_BITS-1:0] REG_TARGET_HIGH = 1'd1;

	localparam logic ACTION_MEASURE = 1'b0;
	localparam logic ACTION_MAP = 1'b1;

	// one map pixel, already reduced to the operands of the scaling
	typedef struct packed {
		logic                  flat;
		logic [PIXEL_BITS-1:0] delta;
		logic [PIXEL_BITS-1:0] span;
		logic [PIXEL_BITS-1:0] under;
		logic [PIXEL_BITS-1:0] low;
	} ghs_cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_MUL,
		BK_DIV,
		BK_OUT
	} ghs_back_state_t;

endpackage

### hdl/gray_histogram_shrink_top.sv
// top level of the gray histogram shrink block
// a map pixel passes through the back end's multiply, divide and out states; a flat-frame one goes straight to out
// throughput: one measure pixel per cycle while the queue is not full; the back end takes one map pixel at a
// time, with a bit-serial divider (one quotient bit per cycle over 16 bits)
// a four-entry command queue lets measure and map transfers run ahead of the divider
// reset: arst_n clears least to 255, greatest to 0, target range to 0..255, queue empty
`timescale 1ns / 1ps
module gray_histogram_shrink_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ghs_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
	input  logic [ghs_pkg::PIXEL_BITS-1:0]    cfg_wdata,
	input  logic                              push,
	output logic                              full,
	input  logic                              action,
	input  logic [ghs_pkg::PIXEL_BITS-1:0]    pixel,
	input  logic                              first,
	output logic                              empty,
	input  logic                              pop,
	output logic [ghs_pkg::PIXEL_BITS-1:0]    shrunk_pixel,
	output logic                              flat_frame
);
	import ghs_pkg::*;

	logic     in_take;
	logic     cmd_push;
	ghs_cmd_t cmd_in;
	ghs_cmd_t cmd_out;
	logic     cmd_full;
	logic     cmd_empty;
	logic     cmd_pop;

	assign full = cmd_full;
	assign in_take = push && !cmd_full;

	ghs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_take   (in_take),
		.action    (action),
		.pixel     (pixel),
		.first     (first),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in)
	);

	ghs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data (cmd_in),
		.full      (cmd_full),
		.pop       (cmd_pop),
		.pop_data  (cmd_out),
		.empty     (cmd_empty)
	);

	ghs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_empty    (cmd_empty),
		.cmd          (cmd_out),
		.cmd_pop      (cmd_pop),
		.empty        (empty),
		.pop          (pop),
		.shrunk_pixel (shrunk_pixel),
		.flat_frame   (flat_frame)
	);

endmodule

### hdl/ghs_front.sv
// front end: config registers, frame min/max tracking, map command build
`timescale 1ns / 1ps
module ghs_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ghs_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
	input  logic [ghs_pkg::PIXEL_BITS-1:0]     cfg_wdata,
	input  logic                               in_take,
	input  logic                               action,
	input  logic [ghs_pkg::PIXEL_BITS-1:0]     pixel,
	input  logic                               first,
	output logic                               cmd_push,
	output ghs_pkg::ghs_cmd_t                  cmd
);
	import ghs_pkg::*;

	logic [PIXEL_BITS-1:0] target_low_q;
	logic [PIXEL_BITS-1:0] target_high_q;
	logic [PIXEL_BITS-1:0] least_q;
	logic [PIXEL_BITS-1:0] greatest_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_low_q <= '0;
			target_high_q <= PIXEL_TOP;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_TARGET_LOW:  target_low_q <= cfg_wdata;
				REG_TARGET_HIGH: target_high_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			least_q <= PIXEL_TOP;
			greatest_q <= '0;
		end else if (in_take && action == ACTION_MEASURE) begin
			if (first) begin
				least_q <= pixel;
				greatest_q <= pixel;
			end else begin
				if (pixel < least_q) least_q <= pixel;
				if (pixel > greatest_q) greatest_q <= pixel;
			end
		end
	end

	assign cmd_push = in_take && action == ACTION_MAP;

	always_comb begin
		cmd.flat = greatest_q <= least_q;
		cmd.delta = (pixel > least_q) ? pixel - least_q : '0;
		cmd.under = greatest_q - least_q;
		cmd.span = (target_high_q >= target_low_q) ? target_high_q - target_low_q
			: target_low_q - target_high_q;
		cmd.low = target_low_q;
	end

endmodule

### hdl/ghs_queue.sv
// short command queue between the front and back parts
`timescale 1ns / 1ps
module ghs_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ghs_pkg::ghs_cmd_t push_data,
	output logic              full,
	input  logic              pop,
	output ghs_pkg::ghs_cmd_t pop_data,
	output logic              empty
);
	import ghs_pkg::*;

	ghs_cmd_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_BITS-1:0] wr_ptr_q;
	logic [QUEUE_PTR_BITS-1:0] rd_ptr_q;
	logic [QUEUE_CNT_BITS-1:0] count_q;
	logic                    do_push;
	logic                    do_pop;

	assign full = count_q == QUEUE_CNT_BITS'(QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### hdl/ghs_back.sv
// back end: multiply, bit-serial divide, offset and saturate, result register
`timescale 1ns / 1ps
`include "gray_histogram_shrink_top_defines.svh"
module ghs_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_empty,
	input  ghs_pkg::ghs_cmd_t              cmd,
	output logic                           cmd_pop,
	output logic                           empty,
	input  logic                           pop,
	output logic [ghs_pkg::PIXEL_BITS-1:0] shrunk_pixel,
	output logic                           flat_frame
);
	import ghs_pkg::*;

	ghs_back_state_t        state_q;
	ghs_back_state_t        state_d;
	logic                   flat_q;
	logic [PIXEL_BITS-1:0]  delta_q;
	logic [PIXEL_BITS-1:0]  span_q;
	logic [PIXEL_BITS-1:0]  under_q;
	logic [PIXEL_BITS-1:0]  low_q;
	logic [PROD_BITS-1:0]   dvd_q;
	logic [PIXEL_BITS-1:0]  rem_q;
	logic [STEP_BITS-1:0]   step_q;
	logic                   res_valid_q;
	logic [PIXEL_BITS-1:0]  res_pixel_q;
	logic                   res_flat_q;

	logic                   out_free;
	logic                   res_load;
	logic                   div_last;
	logic [PIXEL_BITS:0]    trial;
	logic                   fits;
	logic [PROD_BITS:0]     sum;
	logic [PIXEL_BITS-1:0]  res_pixel;

	assign out_free = !res_valid_q || pop;
	assign empty = !res_valid_q;
	assign shrunk_pixel = res_pixel_q;
	assign flat_frame = res_flat_q;
	assign div_last = state_q == BK_DIV && step_q == STEP_BITS'(PROD_BITS - 1);

	// one restoring-division step: bring in the next dividend bit
	assign trial = {rem_q, dvd_q[PROD_BITS-1]};
	assign fits = trial >= {1'b0, under_q};

	assign sum = {{(PROD_BITS-PIXEL_BITS+1){1'b0}}, low_q} + {1'b0, dvd_q};
	always_comb begin
		if (flat_q) res_pixel = low_q;
		else if (sum > {{(PROD_BITS-PIXEL_BITS+1){1'b0}}, PIXEL_TOP}) res_pixel = PIXEL_TOP;
		else res_pixel = sum[PIXEL_BITS-1:0];
	end

	always_comb begin
		state_d = state_q;
		cmd_pop = 1'b0;
		res_load = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					state_d = cmd.flat ? BK_OUT : BK_MUL;
				end
			end
			BK_MUL: state_d = BK_DIV;
			BK_DIV: begin
				if (div_last) state_d = BK_OUT;
			end
			BK_OUT: begin
				if (out_free) begin
					res_load = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= BK_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) step_q <= '0;
		else if (state_q == BK_DIV) step_q <= step_q + 1'b1;
		else step_q <= '0;
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			flat_q <= cmd.flat;
			delta_q <= cmd.delta;
			span_q <= cmd.span;
			under_q <= cmd.under;
			low_q <= cmd.low;
		end
		case (state_q)
			BK_MUL: begin
				dvd_q <= PROD_BITS'(delta_q) * PROD_BITS'(span_q);
				rem_q <= '0;
			end
			BK_DIV: begin
				rem_q <= fits ? PIXEL_BITS'(trial - {1'b0, under_q}) : trial[PIXEL_BITS-1:0];
				dvd_q <= {dvd_q[PROD_BITS-2:0], fits};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid_q <= 1'b0;
		else if (res_load) res_valid_q <= 1'b1;
		else if (pop) res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_pixel_q <= res_pixel;
			res_flat_q <= flat_q;
		end
	end

	`GHS_ASSERT_NOW(a_div_nonzero, state_q == BK_DIV, under_q != '0, "divide by zero in back end")
	`GHS_ASSERT_NOW(a_rem_below, state_q == BK_DIV, rem_q < under_q, "remainder not below divisor")
	`GHS_ASSERT_NEXT(a_div_done, div_last, state_q == BK_OUT, "divide did not end")
	`GHS_ASSERT_NOW(a_load_rise, $rose(res_valid_q), $past(state_q) == BK_OUT, "result not from out")

endmodule

### dv/tb.sv
// self-checking testbench for the gray histogram shrink block
`timescale 1ns / 1ps
module tb;
	import ghs_pkg::*;

	localparam int HOLD_CYCLES = 150;
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 400;
	localparam int PHASE_ITEMS = 50;
	localparam int DIRECTED_ROWS = 24;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
	typedef enum int {RX_STREAM, RX_COIN, RX_SPARSE} rx_mode_t;

	// one directed row: a pixel transfer or a register write
	typedef struct packed {
		row_kind_t                kind;
		logic                     act;
		logic [PIXEL_BITS-1:0]    pix;
		logic                     fst;
		logic                     typed;
		logic [PIXEL_BITS-1:0]    typed_pix;
		logic                     typed_flat;
		logic [CFG_ADDR_BITS-1:0] reg_idx;
		logic [PIXEL_BITS-1:0]    reg_val;
	} stim_row_t;

	typedef struct packed {
		logic [PIXEL_BITS-1:0] pix;
		logic                  flat;
	} shrunk_t;

	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		// map before any measure: flat, target_low
		'{ROW_ITEM, ACTION_MAP,     8'd100, 1'b0, 1'b1, 8'd0,   1'b1, REG_TARGET_LOW, 8'd0},
		'{ROW_ITEM, ACTION_MEASURE, 8'd0,   1'b1, 1'b0, 8'd0,   1'b0, REG_TARGET_LOW, 8'd0},
		'{ROW_ITEM, ACTION_MEASURE, 8'd255, 1'b0, 1'b0, 8'd0,   1'b0, REG_TARGET_LOW, 8'd0},
		'{ROW_ITEM, ACTION_MAP,     8'd0,   1'b0, 1'b1, 8'd0,   1'b0, REG_TARGET_LOW, 8'd0},
		'{ROW_ITEM, ACTION_MAP,     8'd255, 1'b0, 1'b1, 8'd255, 1'b0, REG_TARGET_LOW, 8'd0},
		'{ROW_ITEM, ACTION_MAP,     8'd128, 1'b0, 1'b1, 8'd128, 1'b0, REG_TARGET_LOW, 8'd0},
		// flat frame, also with first set on the map pixel
		'{ROW_ITEM, ACTION_MEASURE, 8'd77,  1'b1, 1'b0, 8'd0,   1'b0, REG_TARGET_LOW, 8'd0},
		'{ROW_ITEM, ACTION_MAP,     8'd77,  1'b0, 1'b1, 8'd0,   1'b1, REG_TARGET_LOW, 8'd0},
		'{ROW_ITEM, ACTION_MAP,     8'd200, 1'b1, 1'b1, 8'd0,   1'b1, REG_TARGET_LOW, 8'd0},
		'{ROW_ITEM, ACTION_MEASURE, 8'd100, 1'b1, 1'b0, 8'd0,   1'b0, REG_TARGET_LOW, 8'd0},
		'{ROW_ITEM, ACTION_MEASURE, 8'd200, 1'b0, 1'b0, 8'd0,   1'b0, REG_TARGET_LOW, 8'd0},
		'{ROW_ITEM, ACTION_MEASURE, 8'd150, 1'b0, 1'b0, 8'd0,   1'b0, REG_TARGET_LOW, 8'd0},
		// below least clamps to target_low, above greatest saturates
		'{ROW_ITEM, ACTION_MAP,     8'd50,  1'b0, 1'b1, 8'd0,   1'b0, REG_TARGET_LOW, 8'd0},
		'{ROW_ITEM, ACTION_MAP,     8'd255, 1'b0, 1'b1, 8'd255, 1'b0, REG_TARGET_LOW, 8'd0},
		'{ROW_ITEM, ACTION_MAP,     8'd150, 1'b1, 1'b0, 8'd0,   1'b0, REG_TARGET_LOW, 8'd0},
		// reversed target range
		'{ROW_CFG,  ACTION_MEASURE, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0, REG_TARGET_LOW, 8'd200},
		'{ROW_CFG,  ACTION_MEASURE, 8'd0,   1'b0, 1'b0, 8'd0,   1'b0, REG_TARGET_HIGH, 8'd100},
		'{ROW_ITEM, ACTION_MEASURE, 8'd0,   1'b1, 1'b0, 8'd0,   1'b0, REG_TARGET_LOW, 8'd0},
		'{ROW_ITEM, ACTION_MEASURE, 8'd255, 1'b0, 1'b0, 8'd0,   1'b0, REG_TARGET_LOW, 8'd0},
		'{ROW_ITEM, ACTION_MAP,     8'd0,   1'b0, 1'b1, 8'd200, 1'b0, REG_TARGET_LOW, 8'd0},
		'{ROW_ITEM, ACTION_MAP,     8'd255, 1'b0, 1'b1, 8'd255, 1'b0, REG_TARGET_LOW, 8'd0},
		'{ROW_ITEM, ACTION_MAP,     8'd90,  1'b0, 1'b0, 8'd0,   1'b0, REG_TARGET_LOW, 8'd0},
		'{ROW_ITEM, ACTION_MEASURE, 8'd9,   1'b1, 1'b0, 8'd0,   1'b0, REG_TARGET_LOW, 8'd0},
		'{ROW_ITEM, ACTION_MAP,     8'd3,   1'b0, 1'b1, 8'd200, 1'b1, REG_TARGET_LOW, 8'd0}
	};

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_ADDR_BITS-1:0] cfg_addr;
	logic [PIXEL_BITS-1:0]    cfg_wdata;
	logic                     push;
	logic                     full;
	logic                     action;
	logic [PIXEL_BITS-1:0]    pixel;
	logic                     first;
	logic                     empty;
	logic                     pop;
	logic [PIXEL_BITS-1:0]    shrunk_pixel;
	logic                     flat_frame;

	// typed-in expectation that travels with the pixel on the bus
	logic                     typed_valid;
	logic [PIXEL_BITS-1:0]    typed_pix;
	logic                     typed_flat;

	// predictor state
	logic [PIXEL_BITS-1:0] tgt_low = '0;
	logic [PIXEL_BITS-1:0] tgt_high = PIXEL_TOP;
	logic [PIXEL_BITS-1:0] frame_lo = PIXEL_TOP;
	logic [PIXEL_BITS-1:0] frame_hi = '0;
	shrunk_t               shrunk_q[$];

	int err_count = 0;
	int items_sent = 0;
	int cycle_count = 0;
	int burst_left = 0;
	bit tx_no_gaps = 0;
	bit rx_hold_req = 0;

	gray_histogram_shrink_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.push(push),
		.full(full),
		.action(action),
		.pixel(pixel),
		.first(first),
		.empty(empty),
		.pop(pop),
		.shrunk_pixel(shrunk_pixel),
		.flat_frame(flat_frame)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic shrunk_t scale_pixel(logic [PIXEL_BITS-1:0] pix);
		int unsigned span;
		int unsigned under;
		int unsigned offset;
		int unsigned res;
		shrunk_t r;
		if (frame_hi <= frame_lo) begin
			r.pix = tgt_low;
			r.flat = 1'b1;
			return r;
		end
		span = (tgt_high >= tgt_low) ? int'(tgt_high) - int'(tgt_low)
		                             : int'(tgt_low) - int'(tgt_high);
		under = int'(frame_hi) - int'(frame_lo);
		offset = (pix > frame_lo) ? int'(pix) - int'(frame_lo) : 0;
		res = int'(tgt_low) + (offset * span) / under;
		if (res > PIXEL_TOP)
			res = PIXEL_TOP;
		r.pix = res[PIXEL_BITS-1:0];
		r.flat = 1'b0;
		return r;
	endfunction

	// predictor and scoreboard, both on the transfer edge
	always @(posedge clk) begin
		shrunk_t want;
		if (arst_n) begin
			if (cfg_we) begin
				if (cfg_addr == REG_TARGET_LOW)
					tgt_low = cfg_wdata;
				else if (cfg_addr == REG_TARGET_HIGH)
					tgt_high = cfg_wdata;
			end
			if (push && !full) begin
				if (action == ACTION_MEASURE) begin
					if (first) begin
						frame_lo = pixel;
						frame_hi = pixel;
					end else begin
						if (pixel < frame_lo)
							frame_lo = pixel;
						if (pixel > frame_hi)
							frame_hi = pixel;
					end
				end else begin
					want = scale_pixel(pixel);
					if (typed_valid) begin
						want.pix = typed_pix;
						want.flat = typed_flat;
					end
					shrunk_q.push_back(want);
				end
			end
			if (pop && !empty) begin
				if (shrunk_q.size() == 0) begin
					$error("result transfer with no expected result");
					err_count++;
				end else begin
					want = shrunk_q.pop_front();
					if (shrunk_pixel !== want.pix) begin
						$error("shrunk_pixel: expected %0d, actual %0d", want.pix, shrunk_pixel);
						err_count++;
					end
					if (flat_frame !== want.flat) begin
						$error("flat_frame: expected %0d, actual %0d", want.flat, flat_frame);
						err_count++;
					end
				end
			end
		end
	end

	// receiver: stall pattern of its own, plus one long hold-off on request
	initial begin
		rx_mode_t mode;
		int mode_left;
		mode = RX_STREAM;
		mode_left = 0;
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				pop <= 1'b0;
				rx_hold_req = 0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(8, 80);
				end
				mode_left--;
				case (mode)
					RX_STREAM: pop <= 1'b1;
					RX_COIN: pop <= 1'($urandom_range(0, 1));
					default: pop <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	task automatic send_item(logic act, logic [PIXEL_BITS-1:0] pix, logic fst,
		logic chk, logic [PIXEL_BITS-1:0] chk_pix, logic chk_flat);
		int gap;
		push <= 1'b1;
		action <= act;
		pixel <= pix;
		first <= fst;
		typed_valid <= chk;
		typed_pix <= chk_pix;
		typed_flat <= chk_flat;
		@(posedge clk);
		while (full) @(posedge clk);
		items_sent++;
		if (!tx_no_gaps) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				// idle gap with junk on the bus
				gap = $urandom_range(1, 12);
				push <= 1'b0;
				action <= 1'($urandom_range(0, 1));
				pixel <= 8'($urandom_range(0, 255));
				first <= 1'($urandom_range(0, 1));
				repeat (gap) @(posedge clk);
				burst_left = $urandom_range(0, 20);
			end
		end
	endtask

	task automatic send_pixel(logic act, logic [PIXEL_BITS-1:0] pix, logic fst);
		send_item(act, pix, fst, 1'b0, '0, 1'b0);
	endtask

	task automatic drain_results();
		push <= 1'b0;
		@(posedge clk);
		while (shrunk_q.size() != 0) @(posedge clk);
	endtask

	// block idle: every result in, then a settle wait before the next step
	task automatic wait_idle();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_ADDR_BITS-1:0] idx, logic [PIXEL_BITS-1:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [PIXEL_BITS-1:0] pick_level();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return PIXEL_TOP;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// one measure pass followed by one map pass
	task automatic run_frame();
		int lo;
		int hi;
		int n_meas;
		int n_map;
		logic [PIXEL_BITS-1:0] p;
		case ($urandom_range(0, 7))
			0: begin
				lo = $urandom_range(0, 255);
				hi = lo;
			end
			1: begin
				lo = 0;
				hi = 255;
			end
			2, 3: begin
				lo = $urandom_range(0, 250);
				hi = lo + $urandom_range(1, 5);
			end
			default: begin
				lo = $urandom_range(0, 255);
				hi = $urandom_range(lo, 255);
			end
		endcase
		n_meas = $urandom_range(1, 6);
		for (int i = 0; i < n_meas; i++) begin
			if (i == 0)
				p = 8'(lo);
			else if (i == 1)
				p = 8'(hi);
			else
				p = 8'($urandom_range(lo, hi));
			send_pixel(ACTION_MEASURE, p, i == 0);
		end
		n_map = $urandom_range(1, 8);
		for (int i = 0; i < n_map; i++) begin
			if ($urandom_range(0, 4) == 0)
				p = 8'($urandom_range(0, 255));
			else
				p = 8'($urandom_range(lo, hi));
			send_pixel(ACTION_MAP, p, 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		stim_row_t row;
		int phase_end;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		push = 1'b0;
		action = ACTION_MEASURE;
		pixel = '0;
		first = 1'b0;
		typed_valid = 1'b0;
		typed_pix = '0;
		typed_flat = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			row = DIRECTED[i];
			if (row.kind == ROW_CFG) begin
				wait_idle();
				write_reg(row.reg_idx, row.reg_val);
			end else begin
				send_item(row.act, row.pix, row.fst, row.typed, row.typed_pix, row.typed_flat);
			end
		end

		for (int phase = 0; items_sent < DIRECTED_ROWS + RANDOM_ITEMS; phase++) begin
			wait_idle();
			case (phase)
				0: begin
					write_reg(REG_TARGET_LOW, PIXEL_TOP);
					write_reg(REG_TARGET_HIGH, '0);
				end
				1: begin
					write_reg(REG_TARGET_LOW, '0);
					write_reg(REG_TARGET_HIGH, PIXEL_TOP);
				end
				2: begin
					write_reg(REG_TARGET_LOW, '0);
					write_reg(REG_TARGET_HIGH, '0);
				end
				default: begin
					write_reg(REG_TARGET_LOW, pick_level());
					write_reg(REG_TARGET_HIGH, pick_level());
				end
			endcase
			if (phase == 1) begin
				// receiver holds off while map pixels keep coming: queue fills, full rises
				tx_no_gaps = 1;
				send_pixel(ACTION_MEASURE, '0, 1'b1);
				send_pixel(ACTION_MEASURE, PIXEL_TOP, 1'b0);
				rx_hold_req = 1;
				repeat (16) send_pixel(ACTION_MAP, 8'($urandom_range(0, 255)), 1'b0);
			end
			tx_no_gaps = ($urandom_range(0, 3) == 0);
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				if ($urandom_range(0, 9) == 0) begin
					// loose items: any action, first anywhere
					repeat ($urandom_range(1, 6))
						send_pixel(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
							1'($urandom_range(0, 1)));
				end else begin
					run_frame();
				end
			end
		end

		wait_idle();
		if (err_count == 0 && shrunk_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
